[rtl/sdmt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdmt_pkg: shared types and constants of the still-dwell motion trigger
// Register indexes, register reset values, field widths and the groups of
// signals passed between the sensor lanes, the control stage and the top.
// ----------------------------------------------------------------------------
package sdmt_pkg;

	// Configuration port widths
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 16;

	// Threshold and dwell register widths
	localparam int LIMIT_W   = 15;
	localparam int PERIOD_W  = 16;

	// Register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_ACC_LIMIT         = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_GRAVITY_LEVEL     = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_GRAVITY_TOLERANCE = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_GYRO_LIMIT        = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_STILL_SAMPLES     = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_STOP_SAMPLES      = 3'd5;

	// Register reset values
	localparam logic [LIMIT_W-1:0]  ACC_LIMIT_RST         = 15'd205;
	localparam logic [LIMIT_W-1:0]  GRAVITY_LEVEL_RST     = 15'd2509;
	localparam logic [LIMIT_W-1:0]  GRAVITY_TOLERANCE_RST = 15'd128;
	localparam logic [LIMIT_W-1:0]  GYRO_LIMIT_RST        = 15'd205;
	localparam logic [PERIOD_W-1:0] STILL_SAMPLES_RST     = 16'd15;
	localparam logic [PERIOD_W-1:0] STOP_SAMPLES_RST      = 16'd5;

	// Still-test thresholds shared by both lanes
	typedef struct packed {
		logic [LIMIT_W-1:0] acc_limit;
		logic [LIMIT_W-1:0] gravity_level;
		logic [LIMIT_W-1:0] gravity_tolerance;
		logic [LIMIT_W-1:0] gyro_limit;
	} thr_t;

	// Dwell and stop periods for the control stage
	typedef struct packed {
		logic [PERIOD_W-1:0] still_samples;
		logic [PERIOD_W-1:0] stop_samples;
	} period_t;

	// Lane results merged by the control stage
	typedef struct packed {
		logic ref_still;
		logic mon_moving;
	} flags_t;

endpackage

[rtl/sdmt_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdmt_if: channel interfaces of the still-dwell motion trigger
// Sample request channel, result channel and configuration write channel,
// each with valid/ready handshake and a source and a sink modport.
// ----------------------------------------------------------------------------
interface sdmt_sample_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic                           valid;
	logic                           ready;
	logic signed [SAMPLE_WIDTH-1:0] ref_acc_x;
	logic signed [SAMPLE_WIDTH-1:0] ref_acc_y;
	logic signed [SAMPLE_WIDTH-1:0] ref_acc_z;
	logic signed [SAMPLE_WIDTH-1:0] ref_rate_x;
	logic signed [SAMPLE_WIDTH-1:0] ref_rate_y;
	logic signed [SAMPLE_WIDTH-1:0] ref_rate_z;
	logic signed [SAMPLE_WIDTH-1:0] mon_acc_x;
	logic signed [SAMPLE_WIDTH-1:0] mon_acc_y;
	logic signed [SAMPLE_WIDTH-1:0] mon_acc_z;
	logic signed [SAMPLE_WIDTH-1:0] mon_rate_x;
	logic signed [SAMPLE_WIDTH-1:0] mon_rate_y;
	logic signed [SAMPLE_WIDTH-1:0] mon_rate_z;

	modport source (
		output valid, ref_acc_x, ref_acc_y, ref_acc_z, ref_rate_x, ref_rate_y, ref_rate_z,
		output mon_acc_x, mon_acc_y, mon_acc_z, mon_rate_x, mon_rate_y, mon_rate_z,
		input  ready
	);
	modport sink (
		input  valid, ref_acc_x, ref_acc_y, ref_acc_z, ref_rate_x, ref_rate_y, ref_rate_z,
		input  mon_acc_x, mon_acc_y, mon_acc_z, mon_rate_x, mon_rate_y, mon_rate_z,
		output ready
	);
endinterface

interface sdmt_result_if;
	logic valid;
	logic ready;
	logic drive_on;
	logic ref_confirmed;
	logic ref_still_now;
	logic mon_moving_now;

	modport source (
		output valid, drive_on, ref_confirmed, ref_still_now, mon_moving_now,
		input  ready
	);
	modport sink (
		input  valid, drive_on, ref_confirmed, ref_still_now, mon_moving_now,
		output ready
	);
endinterface

interface sdmt_cfg_if;
	logic                             valid;
	logic                             ready;
	logic [sdmt_pkg::CFG_INDEX_W-1:0] index;
	logic [sdmt_pkg::CFG_DATA_W-1:0]  data;

	modport source (
		output valid, index, data,
		input  ready
	);
	modport sink (
		input  valid, index, data,
		output ready
	);
endinterface

[rtl/sdmt_still_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdmt_still_lane: still test of one six-axis sensor
// Flags the sensor still when both lateral accelerations, the deviation of
// the vertical acceleration from gravity and all three rates lie strictly
// inside their limits. One lane serves the reference, one the monitored.
// ----------------------------------------------------------------------------
module sdmt_still_lane #(
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic signed [SAMPLE_WIDTH-1:0] acc_x,
	input  logic signed [SAMPLE_WIDTH-1:0] acc_y,
	input  logic signed [SAMPLE_WIDTH-1:0] acc_z,
	input  logic signed [SAMPLE_WIDTH-1:0] rate_x,
	input  logic signed [SAMPLE_WIDTH-1:0] rate_y,
	input  logic signed [SAMPLE_WIDTH-1:0] rate_z,
	input  sdmt_pkg::thr_t                 thr,
	output logic                           still
);

	// Wide enough for a sample minus a threshold without overflow
	localparam int BASE_W = (SAMPLE_WIDTH > sdmt_pkg::LIMIT_W) ? SAMPLE_WIDTH
	                                                           : sdmt_pkg::LIMIT_W;
	localparam int DIFF_W = BASE_W + 2;

	function automatic logic [DIFF_W-1:0] mag_of(input logic signed [DIFF_W-1:0] v);
		mag_of = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
	endfunction

	logic signed [DIFF_W-1:0] grav_e;
	logic signed [DIFF_W-1:0] dz;
	logic        [DIFF_W-1:0] acc_lim_e;
	logic        [DIFF_W-1:0] tol_e;
	logic        [DIFF_W-1:0] rate_lim_e;
	logic                     acc_ok;
	logic                     vert_ok;
	logic                     rate_ok;

	// Extend thresholds and take the vertical deviation
	assign grav_e     = DIFF_W'($signed({1'b0, thr.gravity_level}));
	assign dz         = DIFF_W'(acc_z) - grav_e;
	assign acc_lim_e  = DIFF_W'(thr.acc_limit);
	assign tol_e      = DIFF_W'(thr.gravity_tolerance);
	assign rate_lim_e = DIFF_W'(thr.gyro_limit);

	// Strict compares on every axis
	assign acc_ok  = (mag_of(DIFF_W'(acc_x)) < acc_lim_e) &&
	                 (mag_of(DIFF_W'(acc_y)) < acc_lim_e);
	assign vert_ok = mag_of(dz) < tol_e;
	assign rate_ok = (mag_of(DIFF_W'(rate_x)) < rate_lim_e) &&
	                 (mag_of(DIFF_W'(rate_y)) < rate_lim_e) &&
	                 (mag_of(DIFF_W'(rate_z)) < rate_lim_e);

	assign still = acc_ok && vert_ok && rate_ok;

endmodule

[rtl/sdmt_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdmt_ctrl: dwell and drive control
// Merges the lane flags of one sample: times the reference dwell, confirms
// the reference, switches the drive on at monitored motion and times the
// stop after reference motion. State advances once per step.
// ----------------------------------------------------------------------------
module sdmt_ctrl #(
	parameter int COUNT_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  sdmt_pkg::flags_t  flags,
	input  sdmt_pkg::period_t periods,
	output logic              drive_q,
	output logic              confirmed_q
);

	localparam int CMP_W = (COUNT_WIDTH > sdmt_pkg::PERIOD_W) ? COUNT_WIDTH
	                                                          : sdmt_pkg::PERIOD_W;

	logic [COUNT_WIDTH-1:0] dwell_count_q;
	logic [COUNT_WIDTH-1:0] stop_count_q;
	logic                   dwell_active_q;

	logic [COUNT_WIDTH-1:0] dwell_d;
	logic [COUNT_WIDTH-1:0] stop_d;
	logic                   active_d;
	logic                   conf_d;
	logic                   drive_d;

	// Work out the state after one sample
	always_comb begin
		dwell_d  = dwell_count_q;
		stop_d   = stop_count_q;
		active_d = dwell_active_q;
		conf_d   = confirmed_q;
		drive_d  = drive_q;

		// Advance elapsed counters, saturating
		if (dwell_active_q && (dwell_count_q != '1)) begin
			dwell_d = dwell_count_q + 1'b1;
		end
		if (drive_q && (stop_count_q != '1)) begin
			stop_d = stop_count_q + 1'b1;
		end

		// Reference dwell
		if (flags.ref_still) begin
			if (!conf_d) begin
				if (!active_d) begin
					active_d = 1'b1;
					dwell_d  = '0;
				end
				if (CMP_W'(dwell_d) >= CMP_W'(periods.still_samples)) begin
					conf_d = 1'b1;
				end
			end
		end else begin
			active_d = 1'b0;
			dwell_d  = '0;
			if (conf_d) begin
				conf_d = 1'b0;
				if (drive_d) begin
					stop_d = '0;
				end
			end
		end

		// Drive on at monitored motion while confirmed
		if (conf_d && flags.mon_moving) begin
			drive_d = 1'b1;
		end

		// Drive off once the stop period has run out
		if (drive_d && !conf_d && (CMP_W'(stop_d) >= CMP_W'(periods.stop_samples))) begin
			drive_d = 1'b0;
		end
	end

	// Hold state between steps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_count_q  <= '0;
			stop_count_q   <= '0;
			dwell_active_q <= 1'b0;
			confirmed_q    <= 1'b0;
			drive_q        <= 1'b0;
		end else if (step) begin
			dwell_count_q  <= dwell_d;
			stop_count_q   <= stop_d;
			dwell_active_q <= active_d;
			confirmed_q    <= conf_d;
			drive_q        <= drive_d;
		end
	end

	// Drive switches on only with the reference confirmed
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(drive_q) |-> confirmed_q)
		else $error("drive switched on without confirmed reference");

	// Drive switches off only with the reference unconfirmed
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(drive_q) |-> !confirmed_q)
		else $error("drive switched off while reference confirmed");

	// Confirmation appears only on a step with a still reference
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(confirmed_q) |-> $past(step && flags.ref_still))
		else $error("confirmation without still reference step");

	// State holds between steps
	assert property (@(posedge clk) disable iff (!arst_n)
		!$past(step) |-> ($stable(drive_q) && $stable(confirmed_q) &&
		                  $stable(dwell_count_q) && $stable(stop_count_q)))
		else $error("control state changed without a step");

endmodule

[rtl/still_dwell_motion_trigger_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// still_dwell_motion_trigger_top: still-dwell motion trigger
// Two still-test lanes (reference, monitored) feed a dwell and drive
// control stage. Configuration registers hold thresholds and periods.
//
//   channel  dir  handshake     payload
//   sample   in   valid/ready   ref_* and mon_* acc and rate, SAMPLE_WIDTH
//   result   out  valid/ready   drive_on, ref_confirmed, ref_still_now,
//                               mon_moving_now
//   cfg      in   valid/ready   index (3 bits), data (16 bits)
//
// A request is registered in the lane stage and then in the output stage;
// one request is taken every cycle while the result is not stalled.
// Reset clears the control state and loads the register reset values.
// A stalled result holds the output stage; the lane stage keeps accepting
// while it is empty, so one further request can wait behind a stall.
// Configuration writes are taken every cycle; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module still_dwell_motion_trigger_top #(
	parameter int COUNT_WIDTH  = 16,
	parameter int SAMPLE_WIDTH = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	sdmt_sample_if.sink  sample,
	sdmt_result_if.source result,
	sdmt_cfg_if.sink     cfg
);

	sdmt_pkg::thr_t    thr_q;
	sdmt_pkg::period_t periods_q;

	logic             ref_still;
	logic             mon_still;
	sdmt_pkg::flags_t flags_s1;
	logic             valid_s1;
	logic             ref_still_s2;
	logic             mon_moving_s2;
	logic             result_valid_q;
	logic             advance;
	logic             step;
	logic             drive;
	logic             confirmed;

	// Configuration registers
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q.acc_limit         <= sdmt_pkg::ACC_LIMIT_RST;
			thr_q.gravity_level     <= sdmt_pkg::GRAVITY_LEVEL_RST;
			thr_q.gravity_tolerance <= sdmt_pkg::GRAVITY_TOLERANCE_RST;
			thr_q.gyro_limit        <= sdmt_pkg::GYRO_LIMIT_RST;
			periods_q.still_samples <= sdmt_pkg::STILL_SAMPLES_RST;
			periods_q.stop_samples  <= sdmt_pkg::STOP_SAMPLES_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				sdmt_pkg::REG_ACC_LIMIT:
					thr_q.acc_limit <= cfg.data[sdmt_pkg::LIMIT_W-1:0];
				sdmt_pkg::REG_GRAVITY_LEVEL:
					thr_q.gravity_level <= cfg.data[sdmt_pkg::LIMIT_W-1:0];
				sdmt_pkg::REG_GRAVITY_TOLERANCE:
					thr_q.gravity_tolerance <= cfg.data[sdmt_pkg::LIMIT_W-1:0];
				sdmt_pkg::REG_GYRO_LIMIT:
					thr_q.gyro_limit <= cfg.data[sdmt_pkg::LIMIT_W-1:0];
				sdmt_pkg::REG_STILL_SAMPLES:
					periods_q.still_samples <= cfg.data[sdmt_pkg::PERIOD_W-1:0];
				sdmt_pkg::REG_STOP_SAMPLES:
					periods_q.stop_samples <= cfg.data[sdmt_pkg::PERIOD_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Reference and monitored still-test lanes
	sdmt_still_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_ref_lane (
		.acc_x  (sample.ref_acc_x),
		.acc_y  (sample.ref_acc_y),
		.acc_z  (sample.ref_acc_z),
		.rate_x (sample.ref_rate_x),
		.rate_y (sample.ref_rate_y),
		.rate_z (sample.ref_rate_z),
		.thr    (thr_q),
		.still  (ref_still)
	);

	sdmt_still_lane #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_mon_lane (
		.acc_x  (sample.mon_acc_x),
		.acc_y  (sample.mon_acc_y),
		.acc_z  (sample.mon_acc_z),
		.rate_x (sample.mon_rate_x),
		.rate_y (sample.mon_rate_y),
		.rate_z (sample.mon_rate_z),
		.thr    (thr_q),
		.still  (mon_still)
	);

	// Pipeline handshake: output stage frees when empty or taken
	assign advance      = !result_valid_q || result.ready;
	assign sample.ready = !valid_s1 || advance;
	assign step         = valid_s1 && advance;

	// Lane stage: capture the still flags of an accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.ready) begin
			flags_s1.ref_still  <= ref_still;
			flags_s1.mon_moving <= !mon_still;
		end
	end

	// Merge stage: dwell and drive state
	sdmt_ctrl #(.COUNT_WIDTH(COUNT_WIDTH)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.flags       (flags_s1),
		.periods     (periods_q),
		.drive_q     (drive),
		.confirmed_q (confirmed)
	);

	// Output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			ref_still_s2  <= flags_s1.ref_still;
			mon_moving_s2 <= flags_s1.mon_moving;
		end
	end

	assign result.valid          = result_valid_q;
	assign result.drive_on       = drive;
	assign result.ref_confirmed  = confirmed;
	assign result.ref_still_now  = ref_still_s2;
	assign result.mon_moving_now = mon_moving_s2;

endmodule

[sim/still_dwell_motion_trigger_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// still_dwell_motion_trigger_top_tb: self-checking bench for the motion trigger
// Drives paired reference/monitored sensor samples and register writes, and
// checks every result against a cycle-free model of the dwell, drive-on and
// stop logic, or a fixed verdict. A short directed list opens the run, then
// phases of random still/move sequences, varied thresholds and random idling.
// ----------------------------------------------------------------------------
module still_dwell_motion_trigger_top_tb;
	import sdmt_pkg::*;

	localparam int COUNT_MAX   = 65535;
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYC  = 4;

	// Indexes with no register behind them
	localparam logic [CFG_INDEX_W-1:0] REG_NONE_6 = 3'd6;
	localparam logic [CFG_INDEX_W-1:0] REG_NONE_7 = 3'd7;

	// Axis order inside a sensor: acc x, y, z, rate x, y, z
	typedef logic [5:0][15:0] axes_t;
	// Index 0 is the reference sensor, index 1 the monitored one
	typedef logic [1:0][5:0][15:0] pair_t;

	typedef struct packed {
		logic drive_on;
		logic ref_confirmed;
		logic ref_still_now;
		logic mon_moving_now;
	} verdict_t;

	typedef struct {
		bit                     is_cfg;
		logic [CFG_INDEX_W-1:0] idx;
		int                     data;
		pair_t                  smp;
		bit                     typed;
		verdict_t               want;
	} row_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	sdmt_sample_if #(.SAMPLE_WIDTH(16)) sample_ch ();
	sdmt_result_if                      result_ch ();
	sdmt_cfg_if                         cfg_ch ();

	still_dwell_motion_trigger_top #(
		.COUNT_WIDTH (16),
		.SAMPLE_WIDTH(16)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.sample(sample_ch),
		.result(result_ch),
		.cfg   (cfg_ch)
	);

	always #1 clk = ~clk;

	// Shadow registers and trigger state
	int acc_lim, grav_lvl, grav_tol, gyro_lim, still_n, stop_n;
	int dwell_cnt, stop_cnt;
	bit dwell_on, confirmed, drive;

	verdict_t pending_verdicts [$];
	row_t     plan [$];
	int       mismatches = 0;
	int       items_sent = 0;
	int       gap_pct    = 0;
	int       stall_pct  = 0;
	int       watchdog   = 0;
	bit       cfg_open   = 0;

	function automatic int mag(int v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic bit sensor_still(axes_t s);
		int v [6];
		for (int i = 0; i < 6; i++)
			v[i] = $signed(s[i]);
		return mag(v[0]) < acc_lim && mag(v[1]) < acc_lim &&
			mag(v[2] - grav_lvl) < grav_tol &&
			mag(v[3]) < gyro_lim && mag(v[4]) < gyro_lim && mag(v[5]) < gyro_lim;
	endfunction

	// Advance the trigger state by one sample period and return its outputs
	function automatic verdict_t trigger_step(pair_t smp);
		verdict_t v;
		bit ref_ok;
		bit mon_move;
		ref_ok   = sensor_still(smp[0]);
		mon_move = !sensor_still(smp[1]);
		if (dwell_on && dwell_cnt < COUNT_MAX)
			dwell_cnt++;
		if (drive && stop_cnt < COUNT_MAX)
			stop_cnt++;
		if (ref_ok) begin
			if (!confirmed) begin
				if (!dwell_on) begin
					dwell_on  = 1;
					dwell_cnt = 0;
				end
				if (dwell_cnt >= still_n)
					confirmed = 1;
			end
		end else begin
			dwell_on  = 0;
			dwell_cnt = 0;
			if (confirmed) begin
				confirmed = 0;
				if (drive)
					stop_cnt = 0;
			end
		end
		if (confirmed && mon_move)
			drive = 1;
		if (drive && !confirmed && stop_cnt >= stop_n)
			drive = 0;
		v.drive_on       = drive;
		v.ref_confirmed  = confirmed;
		v.ref_still_now  = ref_ok;
		v.mon_moving_now = mon_move;
		return v;
	endfunction

	function automatic void apply_reg(logic [CFG_INDEX_W-1:0] idx, int data);
		case (idx)
			REG_ACC_LIMIT:         acc_lim  = data & 32'h7FFF;
			REG_GRAVITY_LEVEL:     grav_lvl = data & 32'h7FFF;
			REG_GRAVITY_TOLERANCE: grav_tol = data & 32'h7FFF;
			REG_GYRO_LIMIT:        gyro_lim = data & 32'h7FFF;
			REG_STILL_SAMPLES:     still_n  = data & 32'hFFFF;
			REG_STOP_SAMPLES:      stop_n   = data & 32'hFFFF;
			default: ;
		endcase
	endfunction

	function automatic axes_t axes6(int ax, int ay, int az, int rx, int ry, int rz);
		return {16'(rz), 16'(ry), 16'(rx), 16'(az), 16'(ay), 16'(ax)};
	endfunction

	// One axis value inside or outside the band center +/- lim
	function automatic logic [15:0] gen_axis(int center, int lim, bit in_band);
		int lo, hi, above, below;
		if (in_band) begin
			lo = (center - lim + 1 < -32768) ? -32768 : center - lim + 1;
			hi = (center + lim - 1 > 32767) ? 32767 : center + lim - 1;
			if (lim <= 0 || lo > hi)
				return 16'($urandom);
			case ($urandom_range(3))
				0: return 16'(lo);
				1: return 16'(hi);
				default: return 16'(lo + int'($urandom_range(hi - lo)));
			endcase
		end
		above = center + lim;
		below = center - lim;
		case ($urandom_range(3))
			0: if (above <= 32767) return 16'(above);
			1: if (below >= -32768) return 16'(below);
			default: ;
		endcase
		if (above <= 32767)
			return 16'(above + int'($urandom_range(32767 - above)));
		if (below >= -32768)
			return 16'(below - int'($urandom_range(below + 32768)));
		return 16'($urandom);
	endfunction

	// A sensor reading that is still, or fails on exactly one axis
	function automatic axes_t gen_sensor(bit still);
		axes_t s;
		int bad;
		bad = still ? -1 : int'($urandom_range(5));
		for (int i = 0; i < 6; i++) begin
			if (i < 2)
				s[i] = gen_axis(0, acc_lim, i != bad);
			else if (i == 2)
				s[i] = gen_axis(grav_lvl, grav_tol, i != bad);
			else
				s[i] = gen_axis(0, gyro_lim, i != bad);
		end
		return s;
	endfunction

	function automatic row_t cfg_row(logic [CFG_INDEX_W-1:0] idx, int data);
		row_t r;
		r = '{default: '0};
		r.is_cfg = 1;
		r.idx    = idx;
		r.data   = data;
		return r;
	endfunction

	function automatic row_t item_row(pair_t smp, bit typed, verdict_t want);
		row_t r;
		r = '{default: '0};
		r.smp   = smp;
		r.typed = typed;
		r.want  = want;
		return r;
	endfunction

	task automatic close_cfg();
		if (cfg_open) begin
			cfg_ch.valid <= 1'b0;
			cfg_open = 0;
		end
	endtask

	// Drop the request line and wait until every result is back
	task automatic settle();
		close_cfg();
		sample_ch.valid <= 1'b0;
		while (pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, int data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= 16'(data);
		cfg_open = 1;
		do @(posedge clk); while (!cfg_ch.ready);
		apply_reg(idx, data);
	endtask

	task automatic load_regs(int acc, int grav, int tol, int gyro, int still, int stop);
		settle();
		write_reg(REG_ACC_LIMIT, acc);
		write_reg(REG_GRAVITY_LEVEL, grav);
		write_reg(REG_GRAVITY_TOLERANCE, tol);
		write_reg(REG_GYRO_LIMIT, gyro);
		write_reg(REG_STILL_SAMPLES, still);
		write_reg(REG_STOP_SAMPLES, stop);
	endtask

	// Hand one sample request to the block and record its expected verdict
	task automatic push_sample(pair_t smp, bit typed = 0, verdict_t want = '0);
		verdict_t v;
		close_cfg();
		while ($urandom_range(99) < gap_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid      <= 1'b1;
		sample_ch.ref_acc_x  <= smp[0][0];
		sample_ch.ref_acc_y  <= smp[0][1];
		sample_ch.ref_acc_z  <= smp[0][2];
		sample_ch.ref_rate_x <= smp[0][3];
		sample_ch.ref_rate_y <= smp[0][4];
		sample_ch.ref_rate_z <= smp[0][5];
		sample_ch.mon_acc_x  <= smp[1][0];
		sample_ch.mon_acc_y  <= smp[1][1];
		sample_ch.mon_acc_z  <= smp[1][2];
		sample_ch.mon_rate_x <= smp[1][3];
		sample_ch.mon_rate_y <= smp[1][4];
		sample_ch.mon_rate_z <= smp[1][5];
		do @(posedge clk); while (!sample_ch.ready);
		v = trigger_step(smp);
		pending_verdicts.push_back(typed ? want : v);
		items_sent++;
	endtask

	// Dwell, trigger the drive, move the reference, maybe reconfirm; or noise
	task automatic run_scenario();
		int n_dwell;
		if ($urandom_range(3) == 0) begin
			repeat ($urandom_range(1, 6))
				push_sample({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
			return;
		end
		n_dwell = (still_n > 40) ? int'($urandom_range(40)) : still_n;
		n_dwell += $urandom_range(2);
		for (int i = 0; i <= n_dwell; i++)
			push_sample({gen_sensor($urandom_range(7) != 0), gen_sensor($urandom_range(9) != 0)});
		repeat ($urandom_range(1, 3))
			push_sample({gen_sensor(0), gen_sensor(1)});
		repeat (((stop_n > 20) ? 20 : stop_n) + $urandom_range(3))
			push_sample({gen_sensor($urandom_range(1)), gen_sensor(0)});
		if ($urandom_range(2) == 0)
			repeat ($urandom_range(1, 4))
				push_sample({gen_sensor($urandom_range(1)), gen_sensor(1)});
	endtask

	// Receiver stalls
	initial begin
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			result_ch.ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	// Hard stop if the block hangs
	initial begin
		while (watchdog < CYCLE_LIMIT) begin
			@(posedge clk);
			watchdog++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	// Compare each returned verdict with the oldest outstanding one
	always @(posedge clk) begin
		verdict_t got;
		verdict_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = {result_ch.drive_on, result_ch.ref_confirmed,
				result_ch.ref_still_now, result_ch.mon_moving_now};
			if (pending_verdicts.size() == 0) begin
				mismatches++;
				$display("%0t: result with no request outstanding, got %b", $time, got);
			end else begin
				want = pending_verdicts.pop_front();
				if (got !== want) begin
					mismatches++;
					$display("%0t: drive/confirmed/still/moving expected %b %b %b %b got %b %b %b %b",
						$time, want.drive_on, want.ref_confirmed, want.ref_still_now,
						want.mon_moving_now, got.drive_on, got.ref_confirmed,
						got.ref_still_now, got.mon_moving_now);
				end
			end
		end
	end

	initial begin
		axes_t rest;
		int g;
		int goal;
		int quota [7];

		sample_ch.valid <= 1'b0;
		{sample_ch.ref_acc_x, sample_ch.ref_acc_y, sample_ch.ref_acc_z} <= '0;
		{sample_ch.ref_rate_x, sample_ch.ref_rate_y, sample_ch.ref_rate_z} <= '0;
		{sample_ch.mon_acc_x, sample_ch.mon_acc_y, sample_ch.mon_acc_z} <= '0;
		{sample_ch.mon_rate_x, sample_ch.mon_rate_y, sample_ch.mon_rate_z} <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= '0;
		cfg_ch.data  <= '0;

		acc_lim  = ACC_LIMIT_RST;
		grav_lvl = GRAVITY_LEVEL_RST;
		grav_tol = GRAVITY_TOLERANCE_RST;
		gyro_lim = GYRO_LIMIT_RST;
		still_n  = STILL_SAMPLES_RST;
		stop_n   = STOP_SAMPLES_RST;
		{dwell_cnt, stop_cnt, dwell_on, confirmed, drive} = '0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Directed list; verdict bits are drive/confirmed/still/moving
		g    = GRAVITY_LEVEL_RST;
		rest = axes6(0, 0, g, 0, 0, 0);
		plan.push_back(item_row({axes6(0, 0, 0, 0, 0, 0), axes6(0, 0, 0, 0, 0, 0)}, 1, 4'b0001));
		plan.push_back(item_row({12{16'h8000}}, 1, 4'b0001));
		plan.push_back(item_row({12{16'h7FFF}}, 1, 4'b0001));
		// Zero periods: confirm on the first still sample, drop drive at once
		plan.push_back(cfg_row(REG_STILL_SAMPLES, 0));
		plan.push_back(cfg_row(REG_STOP_SAMPLES, 0));
		plan.push_back(item_row({rest, rest}, 1, 4'b0110));
		plan.push_back(item_row({axes6(205, 0, g, 0, 0, 0), rest}, 1, 4'b1111));
		plan.push_back(item_row({rest, axes6(-205, 0, g, 0, 0, 0)}, 1, 4'b0000));
		// Strict compares: one step inside each band is still, the edge is not
		plan.push_back(item_row({rest, axes6(204, -204, g + 127, 204, -204, 204)}, 1, 4'b0110));
		plan.push_back(item_row({rest, axes6(0, 0, g - 128, 0, 0, 0)}, 1, 4'b0000));
		plan.push_back(item_row({rest, axes6(0, 0, g, 0, 0, -205)}, 1, 4'b0000));
		plan.push_back(item_row({rest, axes6(0, 205, g, 0, 0, 0)}, 1, 4'b0000));
		plan.push_back(item_row({rest, axes6(0, 0, g, 205, -205, 0)}, 1, 4'b0000));
		plan.push_back(item_row({axes6(0, 0, g + 128, 0, 0, 0), axes6(32767, 0, g, 0, 0, 0)},
			1, 4'b0001));
		// Dwell, drive on, stop count, reconfirm during the stop, final stop
		plan.push_back(cfg_row(REG_STILL_SAMPLES, 2));
		plan.push_back(cfg_row(REG_STOP_SAMPLES, 3));
		repeat (3) plan.push_back(item_row({rest, rest}, 0, '0));
		plan.push_back(item_row({axes6(0, 0, 0, 0, 0, 0), rest}, 0, '0));
		plan.push_back(item_row({rest, axes6(-32768, 0, g, 0, 0, 0)}, 0, '0));
		repeat (3) plan.push_back(item_row({rest, rest}, 0, '0));
		plan.push_back(item_row({rest, axes6(0, 0, g, 0, 0, -32768)}, 0, '0));
		repeat (3) plan.push_back(item_row({rest, axes6(0, 32767, g, 0, 0, 0)}, 0, '0));

		foreach (plan[i]) begin
			if (plan[i].is_cfg) begin
				if (!cfg_open)
					settle();
				write_reg(plan[i].idx, plan[i].data);
			end else begin
				push_sample(plan[i].smp, plan[i].typed, plan[i].want);
			end
		end

		// Random phases, each with its own thresholds and idling
		quota = '{300, 300, 300, 150, 400, 200, 300};
		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: begin
					load_regs(205, 2509, 128, 205, 3, 2);
					{gap_pct, stall_pct} = {32'd0, 32'd0};
				end
				1: begin
					load_regs(1000, 0, 500, 50, 0, 0);
					{gap_pct, stall_pct} = {32'd55, 32'd0};
				end
				2: begin
					load_regs(16'hFFFF, 32767, 16'hFFFF, 32767, 7, 10);
					{gap_pct, stall_pct} = {32'd0, 32'd55};
				end
				3: begin
					load_regs(0, 0, 0, 0, 0, 0);
					{gap_pct, stall_pct} = {32'd13, 32'd13};
				end
				4: begin
					load_regs($urandom_range(1, 4000) | ($urandom_range(1) << 15),
						$urandom_range(32767) | ($urandom_range(1) << 15),
						$urandom_range(1, 4000) | ($urandom_range(1) << 15),
						$urandom_range(1, 4000) | ($urandom_range(1) << 15),
						$urandom_range(12), $urandom_range(12));
					{gap_pct, stall_pct} = {32'd13, 32'd13};
				end
				5: begin
					load_regs(300, 2509, 200, 300, 65535, 65535);
					{gap_pct, stall_pct} = {32'd55, 32'd0};
				end
				default: begin
					load_regs(ACC_LIMIT_RST, GRAVITY_LEVEL_RST, GRAVITY_TOLERANCE_RST,
						GYRO_LIMIT_RST, 1, 1);
					write_reg(REG_NONE_6, $urandom_range(16'hFFFF));
					write_reg(REG_NONE_7, $urandom_range(16'hFFFF));
					{gap_pct, stall_pct} = {32'd0, 32'd0};
				end
			endcase
			goal = items_sent + quota[ph];
			while (items_sent < goal)
				run_scenario();
		end

		settle();
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
